// ----- rtl/core/lzfw_pkg.sv -----
// Package for the LZSS flag-word decompressor.
// Holds the window geometry, the parser phase type, the status and operation
// codes and the control struct passed from the parser to the top level.
package lzfw_pkg;

  // History window geometry.
  localparam int WindowSize = 65536;
  localparam int AddrW      = $clog2(WindowSize);
  localparam int ProdW      = $clog2(WindowSize + 1);

  // Operation codes of the input item.
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Status codes of a result item.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadDist = 2'd1;
  localparam logic [1:0] StBusy    = 2'd2;

  typedef enum logic [3:0] {
    PhSize0   = 4'd0,
    PhSize1   = 4'd1,
    PhSize2   = 4'd2,
    PhCtrl    = 4'd3,
    PhFlag0   = 4'd4,
    PhFlag1   = 4'd5,
    PhToken   = 4'd6,
    PhMatchHi = 4'd7,
    PhDist0   = 4'd8,
    PhDist1   = 4'd9,
    PhExt     = 4'd10,
    PhCopy    = 4'd11
  } phase_e;

  // What the parser asks of the window and what the result carries.
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             from_mem;
    logic             byte_valid;
    logic [7:0]       lit_byte;
    logic             copy_pending;
    logic             image_done;
    logic [1:0]       status;
  } lzfw_ctl_t;

endpackage

// ----- rtl/core/lzss_flag_word_decompressor.sv -----
// Top level of the LZSS flag-word decompressor.
// Holds the history window memory, the read stage and the output register.
// Depends on lzfw_pkg and lzfw_parser.
//
//   Channel  Handshake             Payload
//   input    in_valid_i/in_ready_o  operation_i, in_byte_i
//   output   out_valid_o/out_ready_i byte_valid_o, out_byte_o, copy_pending_o,
//                                   image_done_o, status_o
//
// One item is taken per cycle while the output does not stall, literals and copy
// ticks alike, and each gives one result via the read stage and output register.
// The window takes one read for a tick and one write per produced byte, with the
// read data registered. A copy at distance one reads the entry that the previous
// byte is writing in that same cycle; that byte is forwarded.
// Reset clears the parser state and both pipeline stages; the window is not
// cleared, since a valid distance never reaches an entry that was not written.
// When the output is stalled the output register and the read stage each hold
// one result, and the input is taken again as soon as the output drains.
module lzss_flag_word_decompressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic       copy_pending_o,
  output logic       image_done_o,
  output logic [1:0] status_o
);

  lzfw_pkg::lzfw_ctl_t ctl;
  lzfw_pkg::lzfw_ctl_t s1_ctl_q;
  logic       s1_valid_q;
  logic       s1_fwd_q;
  logic       s1_adv;
  logic       accept;
  logic       mem_we;
  logic [7:0] s1_data;
  logic [7:0] rd_data_q;
  logic [7:0] wdata_q;
  logic       out_valid_q;
  logic       byte_valid_q;
  logic [7:0] out_byte_q;
  logic       copy_pending_q;
  logic       image_done_q;
  logic [1:0] status_q;

  // The history window; one write and one registered read per cycle.
  logic [7:0] win_mem [lzfw_pkg::WindowSize];

  // The read stage moves on whenever the output register is free or drains.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  lzfw_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .in_byte_i   (in_byte_i),
    .ctl_o       (ctl)
  );

  // A copy byte comes from the memory, or from the byte written in the cycle
  // of its read when both hit the same entry.
  assign s1_data = s1_ctl_q.from_mem ? (s1_fwd_q ? wdata_q : rd_data_q) : s1_ctl_q.lit_byte;
  assign mem_we  = s1_valid_q && s1_adv && s1_ctl_q.wr_en;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[s1_ctl_q.wr_addr] <= s1_data;
    end
    if (accept && ctl.rd_en) begin
      rd_data_q <= win_mem[ctl.rd_addr];
    end
  end

  // Read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q <= ctl;
      s1_fwd_q <= ctl.rd_en && mem_we && (ctl.rd_addr == s1_ctl_q.wr_addr);
    end
    if (mem_we) begin
      wdata_q <= s1_data;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      byte_valid_q   <= s1_ctl_q.byte_valid;
      out_byte_q     <= s1_data;
      copy_pending_q <= s1_ctl_q.copy_pending;
      image_done_q   <= s1_ctl_q.image_done;
      status_q       <= s1_ctl_q.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_valid_o   = byte_valid_q;
  assign out_byte_o     = out_byte_q;
  assign copy_pending_o = copy_pending_q;
  assign image_done_o   = image_done_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  // A result that reports an error never carries a byte.
  a_err_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != lzfw_pkg::StOk) |-> !byte_valid_o)
    else $error("error result carries a byte");

  // Completing an image leaves no copy pending and no error.
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> (status_o == lzfw_pkg::StOk) && !copy_pending_o)
    else $error("image completed with copy pending or error");

  // Forwarding only applies to bytes that come from the window.
  a_fwd_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_fwd_q |-> s1_ctl_q.from_mem)
    else $error("forwarded data on a non-copy item");

  // Every byte read from the window is written back to it.
  a_copy_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ctl_q.from_mem |-> s1_ctl_q.wr_en && s1_ctl_q.byte_valid)
    else $error("copy byte not written to the window");

  // A stalled output holds its result while the read stage waits.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_byte_q))
    else $error("output register changed during a stall");
`endif

endmodule

// ----- rtl/core/lzfw_parser.sv -----
// Token parser of the LZSS flag-word decompressor.
// Keeps all control state in registers and issues window reads and writes.
// Depends on lzfw_pkg.
module lzfw_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               operation_i,
  input  logic [7:0]         in_byte_i,
  output lzfw_pkg::lzfw_ctl_t ctl_o
);

  lzfw_pkg::phase_e phase_q, phase_d;
  logic [23:0] rem_q, rem_d;
  logic [3:0]  len_bits_q, len_bits_d;
  logic        ext_en_q, ext_en_d;
  logic [15:0] flag_bits_q, flag_bits_d;
  logic [4:0]  flag_left_q, flag_left_d;
  logic [7:0]  tok_low_q, tok_low_d;
  logic [15:0] match_word_q, match_word_d;
  logic [15:0] dist_q, dist_d;
  logic [15:0] copy_rem_q, copy_rem_d;
  logic [lzfw_pkg::ProdW-1:0] prod_q, prod_d;
  logic [lzfw_pkg::AddrW-1:0] wp_q, wp_d;

  logic [15:0] len_mask;
  logic [15:0] mw_hi;
  logic [15:0] dist_hi;
  logic [15:0] dist_lo;
  logic [15:0] chk_mw;
  logic [15:0] chk_dist;
  logic        dist_bad;
  logic        ext_hit;
  logic [15:0] cmw;
  logic [7:0]  extra;
  logic [16:0] len_full;
  logic [15:0] len_clip;
  logic [17:0] src_ext;
  logic [17:0] wp_ext;
  logic [17:0] dist_ext;
  logic [lzfw_pkg::AddrW-1:0] wp_inc;
  logic [lzfw_pkg::ProdW-1:0] prod_inc;
  logic [23:0] rem_dec;
  logic [4:0]  flag_left_dec;

  function automatic lzfw_pkg::phase_e after_token(logic [23:0] rem, logic [4:0] left);
    lzfw_pkg::phase_e ph;
    if (rem == 24'd0) begin
      ph = lzfw_pkg::PhSize0;
    end else if (left != 5'd0) begin
      ph = lzfw_pkg::PhToken;
    end else begin
      ph = lzfw_pkg::PhFlag0;
    end
    return ph;
  endfunction

  // Shared datapath terms.
  always_comb begin
    len_mask = 16'((17'd1 << len_bits_q) - 17'd1);
    mw_hi    = {in_byte_i, tok_low_q};
    dist_hi  = mw_hi >> len_bits_q;
    dist_lo  = {in_byte_i, dist_q[7:0]};
    chk_mw   = (phase_q == lzfw_pkg::PhMatchHi) ? mw_hi : match_word_q;
    chk_dist = (phase_q == lzfw_pkg::PhMatchHi) ? dist_hi : dist_lo;
    dist_bad = (chk_dist == 16'd0) || (18'(chk_dist) > 18'(prod_q));
    ext_hit  = ext_en_q && ((chk_mw & len_mask) == len_mask);
    cmw      = (phase_q == lzfw_pkg::PhExt) ? match_word_q : chk_mw;
    extra    = (phase_q == lzfw_pkg::PhExt) ? in_byte_i : 8'd0;
    len_full = 17'(cmw & len_mask) + 17'(extra) + 17'd3;
    len_clip = (24'(len_full) > rem_q) ? rem_q[15:0] : len_full[15:0];

    wp_ext   = 18'(wp_q);
    dist_ext = 18'(dist_q);
    src_ext  = (wp_ext >= dist_ext) ? (wp_ext - dist_ext)
                                    : (wp_ext + 18'(lzfw_pkg::WindowSize) - dist_ext);

    wp_inc   = (wp_q == lzfw_pkg::AddrW'(lzfw_pkg::WindowSize - 1)) ? '0 : wp_q + 1'b1;
    prod_inc = (prod_q < lzfw_pkg::ProdW'(lzfw_pkg::WindowSize)) ? prod_q + 1'b1 : prod_q;
    rem_dec  = rem_q - 24'd1;
    flag_left_dec = (flag_left_q != 5'd0) ? flag_left_q - 5'd1 : flag_left_q;
  end

  always_comb begin
    phase_d      = phase_q;
    rem_d        = rem_q;
    len_bits_d   = len_bits_q;
    ext_en_d     = ext_en_q;
    flag_bits_d  = flag_bits_q;
    flag_left_d  = flag_left_q;
    tok_low_d    = tok_low_q;
    match_word_d = match_word_q;
    dist_d       = dist_q;
    copy_rem_d   = copy_rem_q;
    prod_d       = prod_q;
    wp_d         = wp_q;

    ctl_o         = '0;
    ctl_o.rd_addr = src_ext[lzfw_pkg::AddrW-1:0];
    ctl_o.wr_addr = wp_q;
    ctl_o.status  = lzfw_pkg::StOk;

    if (operation_i == lzfw_pkg::OpTick) begin
      if ((phase_q == lzfw_pkg::PhCopy) && (copy_rem_q != 16'd0)) begin
        ctl_o.rd_en      = 1'b1;
        ctl_o.from_mem   = 1'b1;
        ctl_o.wr_en      = 1'b1;
        ctl_o.byte_valid = 1'b1;
        wp_d       = wp_inc;
        prod_d     = prod_inc;
        rem_d      = rem_dec;
        copy_rem_d = copy_rem_q - 16'd1;
        if (copy_rem_q == 16'd1) begin
          phase_d = after_token(rem_dec, flag_left_q);
          ctl_o.image_done = (rem_dec == 24'd0);
        end
      end
    end else begin
      unique case (phase_q)
        lzfw_pkg::PhSize0: begin
          rem_d       = 24'(in_byte_i);
          prod_d      = '0;
          flag_left_d = 5'd0;
          flag_bits_d = 16'd0;
          phase_d     = lzfw_pkg::PhSize1;
        end
        lzfw_pkg::PhSize1: begin
          rem_d   = rem_q | {8'd0, in_byte_i, 8'd0};
          phase_d = lzfw_pkg::PhSize2;
        end
        lzfw_pkg::PhSize2: begin
          rem_d   = rem_q | {in_byte_i, 16'd0};
          phase_d = lzfw_pkg::PhCtrl;
        end
        lzfw_pkg::PhCtrl: begin
          len_bits_d = in_byte_i[3:0];
          ext_en_d   = in_byte_i[6];
          phase_d    = after_token(rem_q, flag_left_q);
          ctl_o.image_done = (rem_q == 24'd0);
        end
        lzfw_pkg::PhFlag0: begin
          flag_bits_d = 16'(in_byte_i);
          phase_d     = lzfw_pkg::PhFlag1;
        end
        lzfw_pkg::PhFlag1: begin
          flag_bits_d = flag_bits_q | {in_byte_i, 8'd0};
          flag_left_d = 5'd16;
          phase_d     = lzfw_pkg::PhToken;
        end
        lzfw_pkg::PhToken: begin
          flag_bits_d = flag_bits_q >> 1;
          flag_left_d = flag_left_dec;
          if (flag_bits_q[0]) begin
            ctl_o.wr_en      = 1'b1;
            ctl_o.byte_valid = 1'b1;
            ctl_o.lit_byte   = in_byte_i;
            wp_d   = wp_inc;
            prod_d = prod_inc;
            rem_d  = rem_dec;
            phase_d = after_token(rem_dec, flag_left_dec);
            ctl_o.image_done = (rem_dec == 24'd0);
          end else begin
            tok_low_d = in_byte_i;
            phase_d   = lzfw_pkg::PhMatchHi;
          end
        end
        lzfw_pkg::PhMatchHi, lzfw_pkg::PhDist1: begin
          if (phase_q == lzfw_pkg::PhMatchHi) begin
            match_word_d = mw_hi;
            dist_d       = dist_hi;
          end else begin
            dist_d = dist_lo;
          end
          if ((phase_q == lzfw_pkg::PhMatchHi) && (dist_hi == 16'd0)) begin
            phase_d = lzfw_pkg::PhDist0;
          end else if (dist_bad) begin
            phase_d      = lzfw_pkg::PhSize0;
            copy_rem_d   = 16'd0;
            ctl_o.status = lzfw_pkg::StBadDist;
          end else if (ext_hit) begin
            phase_d = lzfw_pkg::PhExt;
          end else begin
            copy_rem_d = len_clip;
            phase_d    = lzfw_pkg::PhCopy;
          end
        end
        lzfw_pkg::PhDist0: begin
          dist_d  = 16'(in_byte_i);
          phase_d = lzfw_pkg::PhDist1;
        end
        lzfw_pkg::PhExt: begin
          copy_rem_d = len_clip;
          phase_d    = lzfw_pkg::PhCopy;
        end
        lzfw_pkg::PhCopy: begin
          ctl_o.status = lzfw_pkg::StBusy;
        end
        default: begin
          phase_d = lzfw_pkg::PhSize0;
        end
      endcase
    end

    ctl_o.copy_pending = (phase_d == lzfw_pkg::PhCopy) && (copy_rem_d != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lzfw_pkg::PhSize0;
      rem_q        <= '0;
      len_bits_q   <= '0;
      ext_en_q     <= 1'b0;
      flag_bits_q  <= '0;
      flag_left_q  <= '0;
      tok_low_q    <= '0;
      match_word_q <= '0;
      dist_q       <= '0;
      copy_rem_q   <= '0;
      prod_q       <= '0;
      wp_q         <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      rem_q        <= rem_d;
      len_bits_q   <= len_bits_d;
      ext_en_q     <= ext_en_d;
      flag_bits_q  <= flag_bits_d;
      flag_left_q  <= flag_left_d;
      tok_low_q    <= tok_low_d;
      match_word_q <= match_word_d;
      dist_q       <= dist_d;
      copy_rem_q   <= copy_rem_d;
      prod_q       <= prod_d;
      wp_q         <= wp_d;
    end
  end

endmodule
